[rtl/matrix3x3_inverse_determinant_core_macros.svh]
// assertion helpers, clocked on clk, disabled during reset
`ifndef MATRIX3X3_INVERSE_DETERMINANT_CORE_MACROS_SVH
`define MATRIX3X3_INVERSE_DETERMINANT_CORE_MACROS_SVH

`define MI3_PROP(p) @(posedge clk) disable iff (!rst_n) (p)

`define MI3_ASSERT(lbl, p, msg) \
  lbl: assert property (`MI3_PROP(p)) else $error(msg);

`endif

[rtl/mi3_pkg.sv]
package mi3_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int W         = WORD_BITS;

  localparam int CW  = 2 * W + 1;
  localparam int PW  = 2 * W + 1;
  localparam int TW  = 3 * W + 1;
  localparam int DW  = 3 * W + 2;
  localparam int NW  = CW + 2 * FRAC_BITS;
  localparam int XW  = ((NW > DW + W) ? NW : DW + W) + 1;
  localparam int DQW = DW - 2 * FRAC_BITS;

  localparam int LF   = 7;
  localparam int DIVL = W + 1;
  localparam int TOTL = LF + DIVL + 1;

  localparam int IN_TDATA_W  = ((9 * W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((10 * W + 7) / 8) * 8;

  typedef logic signed [W-1:0] word_t;
  typedef logic [CW-1:0]       cmag_t;
  typedef logic [DW-1:0]       dmag_t;

  typedef struct packed {
    logic [8:0]     neg;
    logic           det_neg;
    logic           zero;
    logic [DQW-1:0] dq;
  } side_t;

endpackage

[rtl/mi3_front.sv]
module mi3_front import mi3_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  word_t       a_i [9],
  output cmag_t       cmag_o [9],
  output logic [8:0]  cneg_o,
  output dmag_t       dmag_o,
  output logic        dneg_o,
  output logic        dzero_o
);

  word_t                   a1_r [9];
  logic signed [2*W-1:0]   pa_r [9];
  logic signed [2*W-1:0]   pb_r [9];
  word_t                   a2_r [3];
  word_t                   a3_r [3];
  logic signed [CW-1:0]    c3_r [9];
  logic signed [CW-1:0]    c4_r [9];
  logic signed [CW-1:0]    c5_r [9];
  logic signed [CW-1:0]    c6_r [9];
  logic signed [PW-1:0]    plo_r [3];
  logic signed [PW-1:0]    phi_r [3];
  logic signed [TW-1:0]    t_r [3];
  logic signed [DW-1:0]    det_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        a1_r[k] <= a_i[k];
        c4_r[k] <= c3_r[k];
        c5_r[k] <= c4_r[k];
        c6_r[k] <= c5_r[k];
        cneg_o[k] <= c6_r[k][CW-1];
        cmag_o[k] <= c6_r[k][CW-1] ? (~c6_r[k] + 1'b1) : c6_r[k];
      end
      for (int j = 0; j < 3; j++) begin
        a2_r[j]  <= a1_r[j];
        a3_r[j]  <= a2_r[j];
        plo_r[j] <= a3_r[j] * $signed({1'b0, c3_r[j][W-1:0]});
        phi_r[j] <= a3_r[j] * $signed(c3_r[j][CW-1:W]);
        t_r[j]   <= (TW'(phi_r[j]) <<< W) + TW'(plo_r[j]);
      end
      det_r   <= DW'(t_r[0]) + DW'(t_r[1]) + DW'(t_r[2]);
      dneg_o  <= det_r[DW-1];
      dzero_o <= (det_r == '0);
      dmag_o  <= det_r[DW-1] ? (~det_r + 1'b1) : det_r;
    end
  end

  // cofactor (i,j) = a[i+1][j+1]*a[i+2][j+2] - a[i+1][j+2]*a[i+2][j+1], indices mod 3
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int K  = i * 3 + j;
      localparam int I1 = (i + 1) % 3;
      localparam int I2 = (i + 2) % 3;
      localparam int J1 = (j + 1) % 3;
      localparam int J2 = (j + 2) % 3;
      always_ff @(posedge clk) begin
        if (en) begin
          pa_r[K] <= a1_r[I1*3+J1] * a1_r[I2*3+J2];
          pb_r[K] <= a1_r[I1*3+J2] * a1_r[I2*3+J1];
          c3_r[K] <= $signed({pa_r[K][2*W-1], pa_r[K]}) - $signed({pb_r[K][2*W-1], pb_r[K]});
        end
      end
    end
  end

endmodule

[rtl/mi3_div_lane.sv]
module mi3_div_lane import mi3_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_i,
  input  dmag_t         den_i,
  output logic [W-1:0]  quo_o,
  output logic          ovf_o
);

  logic [XW-1:0] rem_r [0:W-1];
  dmag_t         den_r [0:W-1];
  logic [W-1:0]  q_r   [0:W];
  logic          ovf_r [0:W];

  // quotient at or above 2^W is flagged up front; remaining stages retire one bit each
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= XW'(num_i);
      den_r[0] <= den_i;
      q_r[0]   <= '0;
      ovf_r[0] <= XW'(num_i) >= (XW'(den_i) << W);
    end
  end

  for (genvar i = 1; i <= W; i++) begin : g_stage
    localparam int K = W - i;
    logic [XW:0] diff;
    assign diff = {1'b0, rem_r[i-1]} - ({1'b0, XW'(den_r[i-1])} << K);

    always_ff @(posedge clk) begin
      if (en) begin
        ovf_r[i] <= ovf_r[i-1];
        q_r[i]   <= diff[XW] ? q_r[i-1] : (q_r[i-1] | (W'(1) << K));
      end
    end

    if (i < W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          den_r[i] <= den_r[i-1];
          rem_r[i] <= diff[XW] ? rem_r[i-1] : diff[XW-1:0];
        end
      end
    end
  end

  assign quo_o = q_r[W];
  assign ovf_o = ovf_r[W];

endmodule

[rtl/mi3_merge.sv]
module mi3_merge import mi3_pkg::*; (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] quo_i [9],
  input  logic [8:0]   ovf_i,
  input  side_t        side_i,
  output word_t        inv_o [9],
  output word_t        det_o,
  output logic         singular_o,
  output logic         saturated_o
);

  localparam logic [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};

  logic [W-1:0] val [9];
  logic [8:0]   lsat;
  logic [W-1:0] dval;
  logic         dsat;
  logic         dbig;
  logic         dexact;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      if ((ovf_i[k] || quo_i[k][W-1]) &&
          !(side_i.neg[k] && !ovf_i[k] && quo_i[k] == MIN_W)) begin
        lsat[k] = 1'b1;
        val[k]  = side_i.neg[k] ? MIN_W : MAX_W;
      end else begin
        lsat[k] = 1'b0;
        val[k]  = side_i.neg[k] ? (~quo_i[k] + 1'b1) : quo_i[k];
      end
    end
    dbig   = |side_i.dq[DQW-1:W-1];
    dexact = (side_i.dq[DQW-1:W-1] == (DQW-W+1)'(1)) && (side_i.dq[W-2:0] == '0);
    if (dbig && !(side_i.det_neg && dexact)) begin
      dsat = 1'b1;
      dval = side_i.det_neg ? MIN_W : MAX_W;
    end else begin
      dsat = 1'b0;
      dval = side_i.det_neg ? (~side_i.dq[W-1:0] + 1'b1) : side_i.dq[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        inv_o[k] <= side_i.zero ? '0 : val[k];
      end
      det_o       <= side_i.zero ? '0 : dval;
      singular_o  <= side_i.zero;
      saturated_o <= !side_i.zero && ((|lsat) || dsat);
    end
  end

endmodule

[rtl/matrix3x3_inverse_determinant_core.sv]
// Words pass the front end, nine divider lanes (one quotient bit per stage each), then merge.
// Throughput: one matrix per cycle except while the pipeline is stalled.
// The whole pipeline holds while a result word waits on out_tready.
// Reset (rst_n low, synchronous) clears the stage valid flags only.
`include "matrix3x3_inverse_determinant_core_macros.svh"

module matrix3x3_inverse_determinant_core import mi3_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2, in_r2c0, in_r2c1, in_r2c2
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // inv_r0c0 .. inv_r2c2 (row major), determinant
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // singular, saturated
  output logic [1:0]             out_tuser
);

  logic [TOTL-1:0] vld_r;
  logic            en;

  word_t       a [9];
  cmag_t       cmag [9];
  logic [8:0]  cneg;
  dmag_t       dmag;
  logic        dneg;
  logic        dzero;
  logic [W-1:0] quo [9];
  logic [8:0]  ovf;
  side_t       side_r [0:DIVL-1];
  word_t       inv [9];
  word_t       det;
  logic        singular;
  logic        saturated;

  assign en        = out_tready || !vld_r[TOTL-1];
  assign in_tready = en;
  assign out_tvalid = vld_r[TOTL-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOTL-2:0], in_tvalid};
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_unpack
    assign a[k] = in_tdata[k*W +: W];
  end

  mi3_front u_front (
    .clk     (clk),
    .en      (en),
    .a_i     (a),
    .cmag_o  (cmag),
    .cneg_o  (cneg),
    .dmag_o  (dmag),
    .dneg_o  (dneg),
    .dzero_o (dzero)
  );

  // inverse (r,c) takes cofactor (c,r)
  for (genvar r = 0; r < 3; r++) begin : g_lr
    for (genvar c = 0; c < 3; c++) begin : g_lc
      mi3_div_lane u_lane (
        .clk   (clk),
        .en    (en),
        .num_i ({cmag[c*3+r], {(2*FRAC_BITS){1'b0}}}),
        .den_i (dmag),
        .quo_o (quo[r*3+c]),
        .ovf_o (ovf[r*3+c])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          side_r[0].neg[r*3+c] <= cneg[c*3+r] ^ dneg;
        end
      end
      side_r[0].det_neg <= dneg;
      side_r[0].zero    <= dzero;
      side_r[0].dq      <= dmag[DW-1:2*FRAC_BITS];
      for (int i = 1; i < DIVL; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  mi3_merge u_merge (
    .clk         (clk),
    .en          (en),
    .quo_i       (quo),
    .ovf_i       (ovf),
    .side_i      (side_r[DIVL-1]),
    .inv_o       (inv),
    .det_o       (det),
    .singular_o  (singular),
    .saturated_o (saturated)
  );

  always_comb begin
    out_tdata = '0;
    for (int k = 0; k < 9; k++) begin
      out_tdata[k*W +: W] = inv[k];
    end
    out_tdata[9*W +: W] = det;
  end

  assign out_tuser = {saturated, singular};

  `MI3_ASSERT(a_singular_zero, out_tvalid && out_tuser[0] |-> out_tdata == '0 && !out_tuser[1], "singular word carries data")
  `MI3_ASSERT(a_accept_enters, in_tvalid && in_tready |=> vld_r[0], "accepted word lost")
  `MI3_ASSERT(a_stall_freeze, out_tvalid && !out_tready |=> $stable(vld_r), "pipeline moved during stall")

endmodule
